/* rtl/permutation_cycle_power_count_defines.svh */
// ---------------------------------------------------------------------------
// permutation cycle power count: assertion macros
// shared property forms for the checks ending pcpc_back, one of the rtl modules
// ---------------------------------------------------------------------------
`ifndef PERMUTATION_CYCLE_POWER_COUNT_DEFINES_SVH
`define PERMUTATION_CYCLE_POWER_COUNT_DEFINES_SVH

// condition must hold in the same cycle
`define PCPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the following cycle
`define PCPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition must never hold
`define PCPC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* rtl/pcpc_pkg.sv */
// ---------------------------------------------------------------------------
// pcpc_pkg
// shared types and constants of the permutation cycle power count block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcpc_pkg;

  localparam int MAX_COLUMNS_DEF = 1024;
  localparam int FIELD_W         = 11;
  localparam int ANS_W           = 30;
  localparam logic [ANS_W:0] ANSWER_MODULUS = 31'd1000000007;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  typedef enum logic [2:0] {
    B_INIT_CLR,
    B_IDLE,
    B_SCAN_RD,
    B_SCAN_CHK,
    B_WALK_RD,
    B_WALK_CHK,
    B_CLR
  } back_state_t;

endpackage

/* rtl/pcpc_front.sv */
// ---------------------------------------------------------------------------
// pcpc_front
// accepts columns, range-checks the values and counts the columns of a run
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcpc_front #(
  parameter int MAX_COLUMNS = pcpc_pkg::MAX_COLUMNS_DEF,
  parameter int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  parameter int CNT_W = $clog2(MAX_COLUMNS + 1),
  parameter int ENT_W = 2 + 2 * IDX_W + CNT_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [pcpc_pkg::FIELD_W-1:0] top_value,
  input  logic [pcpc_pkg::FIELD_W-1:0] bottom_value,
  input  logic                         last_column,
  output logic                         push,
  output logic [ENT_W-1:0]             entry
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] count_inc;
  logic             top_ok;
  logic             bot_ok;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] bot_idx;

  always_comb begin
    top_ok    = (top_value != '0) && (32'(top_value) <= 32'(MAX_COLUMNS));
    bot_ok    = (bottom_value != '0) && (32'(bottom_value) <= 32'(MAX_COLUMNS));
    top_idx   = IDX_W'(32'(top_value) - 32'd1);
    bot_idx   = IDX_W'(32'(bottom_value) - 32'd1);
    count_inc = (count_r < CNT_W'(MAX_COLUMNS)) ? count_r + CNT_W'(1) : count_r;
    count_nxt = count_r;
    if (accept) begin
      count_nxt = last_column ? '0 : count_inc;
    end
    push  = accept;
    entry = {top_ok && bot_ok, last_column, top_idx, bot_idx, count_inc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/pcpc_fifo.sv */
// ---------------------------------------------------------------------------
// pcpc_fifo
// short queue of classified columns between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcpc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rd_data,
  output pcpc_pkg::fifo_stat_t stat
);

  logic [WIDTH-1:0]              mem [pcpc_pkg::QUEUE_DEPTH];
  logic [pcpc_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [pcpc_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [pcpc_pkg::QPTR_W:0]     fill_r;
  logic [pcpc_pkg::QPTR_W:0]     fill_nxt;

  always_comb begin
    stat.full  = (fill_r == (pcpc_pkg::QPTR_W + 1)'(pcpc_pkg::QUEUE_DEPTH));
    stat.empty = (fill_r == '0);
    rd_data    = mem[rd_ptr_r];
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/pcpc_back.sv */
// ---------------------------------------------------------------------------
// pcpc_back
// writes the map, walks every cycle of the mapping and doubles the answer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "permutation_cycle_power_count_defines.svh"

module pcpc_back #(
  parameter int MAX_COLUMNS = pcpc_pkg::MAX_COLUMNS_DEF,
  parameter int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
  parameter int CNT_W = $clog2(MAX_COLUMNS + 1),
  parameter int ENT_W = 2 + 2 * IDX_W + CNT_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcpc_pkg::fifo_stat_t       fifo_stat,
  input  logic [ENT_W-1:0]           entry,
  output logic                       pop,
  output pcpc_pkg::back_stat_t       stat,
  output logic                       out_strobe,
  output logic [pcpc_pkg::ANS_W-1:0] out_count
);

  localparam int AW = pcpc_pkg::ANS_W;

  logic [IDX_W-1:0]      map_mem_d [MAX_COLUMNS];
  logic                  vis_mem [MAX_COLUMNS];

  pcpc_pkg::back_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      ptr_r, ptr_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [AW-1:0]         ans_r, ans_nxt;
  logic                  strobe_r, strobe_nxt;
  logic [AW-1:0]         count_r, count_nxt;

  logic                  e_wr;
  logic                  e_last;
  logic [IDX_W-1:0]      e_top;
  logic [IDX_W-1:0]      e_bot;
  logic [CNT_W-1:0]      e_n;

  logic [IDX_W-1:0]      rd_addr;
  logic                  vis_rd_r;
  logic [IDX_W-1:0]      map_rd_r;
  logic                  vis_we;
  logic [IDX_W-1:0]      vis_waddr;
  logic                  vis_wdata;
  logic                  map_we;
  logic [AW:0]           dbl;
  logic [AW-1:0]         ans_dbl;

  assign {e_wr, e_last, e_top, e_bot, e_n} = entry;

  always_comb begin
    dbl     = {ans_r, 1'b0};
    ans_dbl = (dbl >= pcpc_pkg::ANSWER_MODULUS) ?
              AW'(dbl - pcpc_pkg::ANSWER_MODULUS) : dbl[AW-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    n_nxt      = n_r;
    ptr_nxt    = ptr_r;
    j_nxt      = j_r;
    ans_nxt    = ans_r;
    strobe_nxt = 1'b0;
    count_nxt  = count_r;
    pop        = 1'b0;
    map_we     = 1'b0;
    rd_addr    = i_r[IDX_W-1:0];
    vis_we     = 1'b0;
    vis_waddr  = ptr_r[IDX_W-1:0];
    vis_wdata  = 1'b0;
    unique case (state_r)
      pcpc_pkg::B_INIT_CLR: begin
        vis_we = 1'b1;
        if (ptr_r == CNT_W'(MAX_COLUMNS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = pcpc_pkg::B_IDLE;
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      pcpc_pkg::B_IDLE: begin
        if (!fifo_stat.empty) begin
          pop    = 1'b1;
          map_we = e_wr;
          if (e_last) begin
            n_nxt     = e_n;
            i_nxt     = '0;
            ans_nxt   = AW'(1);
            state_nxt = pcpc_pkg::B_SCAN_RD;
          end
        end
      end
      pcpc_pkg::B_SCAN_RD: begin
        if (i_r == n_r) begin
          strobe_nxt = 1'b1;
          count_nxt  = ans_r;
          ptr_nxt    = '0;
          state_nxt  = pcpc_pkg::B_CLR;
        end else begin
          state_nxt = pcpc_pkg::B_SCAN_CHK;
        end
      end
      pcpc_pkg::B_SCAN_CHK: begin
        if (vis_rd_r) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = pcpc_pkg::B_SCAN_RD;
        end else begin
          ans_nxt   = ans_dbl;
          vis_we    = 1'b1;
          vis_waddr = i_r[IDX_W-1:0];
          vis_wdata = 1'b1;
          j_nxt     = map_rd_r;
          state_nxt = pcpc_pkg::B_WALK_RD;
        end
      end
      pcpc_pkg::B_WALK_RD: begin
        rd_addr = j_r;
        if (CNT_W'(j_r) >= n_r) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = pcpc_pkg::B_SCAN_RD;
        end else begin
          state_nxt = pcpc_pkg::B_WALK_CHK;
        end
      end
      pcpc_pkg::B_WALK_CHK: begin
        rd_addr = j_r;
        if (vis_rd_r) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = pcpc_pkg::B_SCAN_RD;
        end else begin
          vis_we    = 1'b1;
          vis_waddr = j_r;
          vis_wdata = 1'b1;
          j_nxt     = map_rd_r;
          state_nxt = pcpc_pkg::B_WALK_RD;
        end
      end
      pcpc_pkg::B_CLR: begin
        vis_we = 1'b1;
        if (ptr_r + CNT_W'(1) >= n_r) begin
          ptr_nxt   = '0;
          ans_nxt   = AW'(1);
          state_nxt = pcpc_pkg::B_IDLE;
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = pcpc_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pcpc_pkg::B_INIT_CLR;
      i_r      <= '0;
      n_r      <= '0;
      ptr_r    <= '0;
      j_r      <= '0;
      ans_r    <= AW'(1);
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      i_r      <= i_nxt;
      n_r      <= n_nxt;
      ptr_r    <= ptr_nxt;
      j_r      <= j_nxt;
      ans_r    <= ans_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

  // map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem_d[e_top] <= e_bot;
    end
    map_rd_r <= map_mem_d[rd_addr];
  end

  // visited bitmap: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rd_r <= vis_mem[rd_addr];
  end

  assign stat.init_busy = (state_r == pcpc_pkg::B_INIT_CLR);
  assign out_strobe     = strobe_r;
  assign out_count      = count_r;

  `PCPC_ASSERT_NEVER(a_ans_below_mod, (AW + 1)'(ans_r) >= pcpc_pkg::ANSWER_MODULUS, "answer not reduced")
  `PCPC_ASSERT_NEXT(a_strobe_single, strobe_r, !strobe_r, "result strobe held for two cycles")
  `PCPC_ASSERT_SAME(a_walk_after_rd, state_r == pcpc_pkg::B_WALK_CHK, $past(state_r) == pcpc_pkg::B_WALK_RD, "walk check without read")
  `PCPC_ASSERT_SAME(a_scan_bound, state_r == pcpc_pkg::B_SCAN_CHK, i_r < n_r, "scan index beyond run length")

endmodule

/* rtl/permutation_cycle_power_count.sv */
// ---------------------------------------------------------------------------
// permutation cycle power count
// loads a pair of permutations column by column and returns 2^cycles mod p
// ---------------------------------------------------------------------------
// use: drive in_top_value, in_bottom_value, in_last_column with start high;
// the column is taken at a clock edge where start is high and busy is low.
// columns enter a four-entry queue, so loading runs at one column per cycle
// until the queue fills during a walk or clear; busy then holds columns off.
// on a column with in_last_column set, the back end walks every cycle of
// the top to bottom mapping, with a read state and a check state for each
// column scanned and for each map step of a walk, then emits the result.
// out_strobe is high for exactly one cycle with out_configuration_count;
// the receiver cannot stall and must take it in that cycle.
// after each result the first n entries of the visited bitmap are cleared
// through its single write port; the queue keeps accepting columns meanwhile.
// after reset busy stays high while the whole visited bitmap is cleared;
// the map memory is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_cycle_power_count #(
  parameter int MAX_COLUMNS = pcpc_pkg::MAX_COLUMNS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [pcpc_pkg::FIELD_W-1:0] in_top_value,
  input  logic [pcpc_pkg::FIELD_W-1:0] in_bottom_value,
  input  logic                         in_last_column,
  output logic                         out_strobe,
  output logic [pcpc_pkg::ANS_W-1:0]   out_configuration_count
);

  localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int ENT_W = 2 + 2 * IDX_W + CNT_W;

  logic                 accept;
  logic                 push;
  logic                 pop;
  logic [ENT_W-1:0]     wr_entry;
  logic [ENT_W-1:0]     rd_entry;
  pcpc_pkg::fifo_stat_t fifo_stat;
  pcpc_pkg::back_stat_t back_stat;

  assign busy   = fifo_stat.full || back_stat.init_busy;
  assign accept = start && !busy;

  pcpc_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W),
    .ENT_W       (ENT_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .top_value    (in_top_value),
    .bottom_value (in_bottom_value),
    .last_column  (in_last_column),
    .push         (push),
    .entry        (wr_entry)
  );

  pcpc_fifo #(
    .WIDTH (ENT_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_data (rd_entry),
    .stat    (fifo_stat)
  );

  pcpc_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W),
    .ENT_W       (ENT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .entry      (rd_entry),
    .pop        (pop),
    .stat       (back_stat),
    .out_strobe (out_strobe),
    .out_count  (out_configuration_count)
  );

endmodule

/* bench/cycle_count_checker.sv */
// ---------------------------------------------------------------------------
// cycle count checker
// watches the column and result channels of the permutation cycle power
// count block, keeps its own copy of the map memory, predicts the count for
// every run on its last column and compares each strobed result in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cycle_count_checker #(
  parameter int MAX_COLUMNS = pcpc_pkg::MAX_COLUMNS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [pcpc_pkg::FIELD_W-1:0] in_top_value,
  input  logic [pcpc_pkg::FIELD_W-1:0] in_bottom_value,
  input  logic                         in_last_column,
  input  logic                         out_strobe,
  input  logic [pcpc_pkg::ANS_W-1:0]   out_configuration_count,
  output int unsigned                  mismatches,
  output int unsigned                  outstanding
);

  localparam int IDX_W  = $clog2(MAX_COLUMNS);
  localparam int EXP_AW = 4;

  typedef logic [pcpc_pkg::FIELD_W-1:0] field_t;

  logic [IDX_W-1:0]           partner_map [MAX_COLUMNS];
  field_t                     column_count = '0;
  logic [pcpc_pkg::ANS_W-1:0] expected_counts [1 << EXP_AW];
  logic [EXP_AW-1:0]          exp_wr = '0;
  logic [EXP_AW-1:0]          exp_rd = '0;
  int unsigned                exp_level = 0;
  int unsigned                fail_total = 0;
  int unsigned                awaited = 0;

  assign mismatches  = fail_total;
  assign outstanding = awaited;

  // one doubling per cycle of the mapping over indexes below n
  function automatic logic [pcpc_pkg::ANS_W-1:0] count_configurations(
    input int unsigned n
  );
    bit                       seen [MAX_COLUMNS];
    logic [pcpc_pkg::ANS_W:0] answer;
    int unsigned              i;
    int unsigned              j;
    answer = (pcpc_pkg::ANS_W + 1)'(1);
    for (i = 0; i < n; i++) begin
      if (!seen[i]) begin
        answer = answer << 1;
        if (answer >= pcpc_pkg::ANSWER_MODULUS) begin
          answer = answer - pcpc_pkg::ANSWER_MODULUS;
        end
        j = i;
        while (j < n && !seen[j]) begin
          seen[j] = 1'b1;
          j = 32'(partner_map[j]);
        end
      end
    end
    return answer[pcpc_pkg::ANS_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [pcpc_pkg::ANS_W-1:0] expected;
    if (!rst_n) begin
      foreach (partner_map[k]) begin
        partner_map[k] = '0;
      end
      column_count = '0;
      exp_wr       = '0;
      exp_rd       = '0;
      exp_level    = 0;
    end else begin
      if (out_strobe) begin
        if (exp_level == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, out_configuration_count);
          fail_total <= fail_total + 1;
        end else begin
          expected  = expected_counts[exp_rd];
          exp_rd    = exp_rd + EXP_AW'(1);
          exp_level = exp_level - 1;
          if (out_configuration_count !== expected) begin
            $display("%0t: configuration count mismatch, expected %0d, actual %0d",
                     $time, expected, out_configuration_count);
            fail_total <= fail_total + 1;
          end
        end
      end
      if (start && !busy) begin
        if (in_top_value >= 1 && in_top_value <= MAX_COLUMNS &&
            in_bottom_value >= 1 && in_bottom_value <= MAX_COLUMNS) begin
          partner_map[IDX_W'(in_top_value - 1)] = IDX_W'(in_bottom_value - 1);
        end
        if (column_count < MAX_COLUMNS) begin
          column_count = column_count + field_t'(1);
        end
        if (in_last_column) begin
          expected_counts[exp_wr] = count_configurations(32'(column_count));
          exp_wr       = exp_wr + EXP_AW'(1);
          exp_level    = exp_level + 1;
          column_count = '0;
        end
      end
    end
    awaited <= exp_level;
  end

endmodule

/* bench/tb_permutation_cycle_power_count.sv */
// ---------------------------------------------------------------------------
// permutation cycle power count testbench
// feeds runs of columns: a few hand-picked runs, then random permutation
// pairs, loose and corrupted runs and one run past the column limit, with
// random gaps; the checker predicts and compares every count
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_permutation_cycle_power_count;

  localparam int COLUMNS     = pcpc_pkg::MAX_COLUMNS_DEF;
  localparam int ITEM_TARGET = 1300;
  localparam int FIELD_TOP   = (1 << pcpc_pkg::FIELD_W) - 1;

  typedef logic [pcpc_pkg::FIELD_W-1:0] field_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  field_t                     in_top_value = '0;
  field_t                     in_bottom_value = '0;
  logic                       in_last_column = 1'b0;
  logic                       busy;
  logic                       out_strobe;
  logic [pcpc_pkg::ANS_W-1:0] out_configuration_count;
  int unsigned                mismatches;
  int unsigned                outstanding;

  bit          index_loaded [COLUMNS];
  int unsigned columns_sent = 0;
  int unsigned gap_mode = 0;

  always #5 clk = ~clk;

  permutation_cycle_power_count #(.MAX_COLUMNS(COLUMNS)) uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_top_value           (in_top_value),
    .in_bottom_value        (in_bottom_value),
    .in_last_column         (in_last_column),
    .out_strobe             (out_strobe),
    .out_configuration_count(out_configuration_count)
  );

  cycle_count_checker #(.MAX_COLUMNS(COLUMNS)) count_check (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_top_value           (in_top_value),
    .in_bottom_value        (in_bottom_value),
    .in_last_column         (in_last_column),
    .out_strobe             (out_strobe),
    .out_configuration_count(out_configuration_count),
    .mismatches             (mismatches),
    .outstanding            (outstanding)
  );

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (gap_mode == 0) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return 0;
    end
    if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_column(input field_t top, input field_t bottom, input logic last);
    int unsigned gap;
    start           <= 1'b1;
    in_top_value    <= top;
    in_bottom_value <= bottom;
    in_last_column  <= last;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    if (top >= 1 && top <= COLUMNS && bottom >= 1 && bottom <= COLUMNS) begin
      index_loaded[top - 1] = 1'b1;
    end
    columns_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // tops cover 1..n and corruption hits only written indexes, so every index the walk reads has been written
  task automatic send_run(input int unsigned n, input int unsigned extra, input bit loose,
                          input bit broken);
    field_t      tops [COLUMNS];
    field_t      bottoms [COLUMNS];
    field_t      swap_v;
    field_t      t;
    field_t      b;
    int unsigned k;
    int unsigned r;
    gap_mode = $urandom_range(0, 2);
    for (k = 0; k < n; k++) begin
      tops[k]    = field_t'(k + 1);
      bottoms[k] = loose ? field_t'($urandom_range(1, COLUMNS)) : field_t'(k + 1);
    end
    for (k = n - 1; k > 0; k--) begin
      r          = $urandom_range(0, k);
      swap_v     = tops[k];
      tops[k]    = tops[r];
      tops[r]    = swap_v;
      r          = $urandom_range(0, k);
      swap_v     = bottoms[k];
      bottoms[k] = bottoms[r];
      bottoms[r] = swap_v;
    end
    for (k = 0; k < n + extra; k++) begin
      if (k < n) begin
        t = tops[k];
        b = bottoms[k];
      end else begin
        t = field_t'($urandom_range(1, COLUMNS));
        b = field_t'($urandom_range(1, FIELD_TOP));
      end
      // corrupt only columns whose index already holds a written entry
      if (broken && $urandom_range(0, 3) == 0 && index_loaded[t - 1]) begin
        case ($urandom_range(0, 4))
          0: begin
            t = '0;
          end
          1: begin
            t = field_t'($urandom_range(COLUMNS + 1, FIELD_TOP));
          end
          2: begin
            b = '0;
          end
          3: begin
            b = field_t'($urandom_range(COLUMNS + 1, FIELD_TOP));
          end
          default: begin
            t = field_t'($urandom_range(1, COLUMNS));
          end
        endcase
      end
      send_column(t, b, k == n + extra - 1);
    end
  endtask

  initial begin : stimulus
    bit          full_run_done;
    int unsigned n;
    full_run_done = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single column, swap, identity, mixed cycles
    send_column(field_t'(1), field_t'(1), 1'b1);
    send_column(field_t'(1), field_t'(2), 1'b0);
    send_column(field_t'(2), field_t'(1), 1'b1);
    send_column(field_t'(1), field_t'(1), 1'b0);
    send_column(field_t'(2), field_t'(2), 1'b1);
    send_column(field_t'(1), field_t'(3), 1'b0);
    send_column(field_t'(2), field_t'(2), 1'b0);
    send_column(field_t'(3), field_t'(1), 1'b1);
    // walk leaves the run
    send_column(field_t'(1), field_t'(5), 1'b0);
    send_column(field_t'(2), field_t'(1), 1'b0);
    send_column(field_t'(3), field_t'(3), 1'b1);
    // out of range values and the top value
    send_column(field_t'(FIELD_TOP), '0, 1'b0);
    send_column('0, field_t'(FIELD_TOP), 1'b0);
    send_column(field_t'(COLUMNS), field_t'(COLUMNS), 1'b1);

    while (columns_sent < ITEM_TARGET) begin
      if (!full_run_done && columns_sent >= 250) begin
        send_run(COLUMNS, $urandom_range(1, 12), 1'b0, 1'b0);
        full_run_done = 1'b1;
      end else begin
        n = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        send_run(n, 0, $urandom_range(0, 5) == 0, $urandom_range(0, 4) == 0);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    wait (outstanding == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pcpc_pkg.sv
rtl/pcpc_front.sv
rtl/pcpc_fifo.sv
rtl/pcpc_back.sv
rtl/permutation_cycle_power_count.sv
bench/cycle_count_checker.sv
bench/tb_permutation_cycle_power_count.sv
